// ===== sv/gpio_controller_set_clear_regs_defines.svh =====
// Assertion helpers for the GPIO controller.
`ifndef GPIO_CONTROLLER_SET_CLEAR_REGS_DEFINES_SVH
`define GPIO_CONTROLLER_SET_CLEAR_REGS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GCSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GCSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gpiosc_pkg.sv =====
package gpiosc_pkg;

    // Item kinds
    typedef enum logic [2:0] {
        FUNC_WRITE = 3'd0,
        FUNC_READ  = 3'd1,
        FUNC_PIN   = 3'd2,
        FUNC_PERA  = 3'd3,
        FUNC_PERB  = 3'd4
    } t_func;

    // Write offsets
    localparam logic [7:0] OFF_PIO_EN   = 8'h00;
    localparam logic [7:0] OFF_PIO_DIS  = 8'h04;
    localparam logic [7:0] OFF_OUT_EN   = 8'h10;
    localparam logic [7:0] OFF_OUT_DIS  = 8'h14;
    localparam logic [7:0] OFF_FLT_EN   = 8'h20;
    localparam logic [7:0] OFF_FLT_DIS  = 8'h24;
    localparam logic [7:0] OFF_SET_DATA = 8'h30;
    localparam logic [7:0] OFF_CLR_DATA = 8'h34;
    localparam logic [7:0] OFF_DATA     = 8'h38;
    localparam logic [7:0] OFF_IRQ_EN   = 8'h40;
    localparam logic [7:0] OFF_IRQ_DIS  = 8'h44;
    localparam logic [7:0] OFF_MD_EN    = 8'h50;
    localparam logic [7:0] OFF_MD_DIS   = 8'h54;
    localparam logic [7:0] OFF_PU_DIS   = 8'h60;
    localparam logic [7:0] OFF_PU_EN    = 8'h64;
    localparam logic [7:0] OFF_SEL_A    = 8'h70;
    localparam logic [7:0] OFF_SEL_B    = 8'h74;
    localparam logic [7:0] OFF_WR_EN    = 8'hA0;
    localparam logic [7:0] OFF_WR_DIS   = 8'hA4;

    // Read offsets (output data shares OFF_DATA)
    localparam logic [7:0] OFF_PIO_STAT = 8'h08;
    localparam logic [7:0] OFF_OUT_STAT = 8'h18;
    localparam logic [7:0] OFF_FLT_STAT = 8'h28;
    localparam logic [7:0] OFF_PIN_STAT = 8'h3C;
    localparam logic [7:0] OFF_IRQ_MASK = 8'h48;
    localparam logic [7:0] OFF_IRQ_STAT = 8'h4C;
    localparam logic [7:0] OFF_MD_STAT  = 8'h58;
    localparam logic [7:0] OFF_PU_STAT  = 8'h68;
    localparam logic [7:0] OFF_SEL_STAT = 8'h78;
    localparam logic [7:0] OFF_WR_STAT  = 8'hA8;

    // One input item
    typedef struct packed {
        t_func       func;
        logic [7:0]  reg_offset;
        logic        word_access;
        logic [31:0] data_in;
        logic        debugger_access;
    } t_req;

    // One result item
    typedef struct packed {
        logic [31:0] read_data;
        logic        access_error;
        logic [31:0] pin_out;
        logic [31:0] pin_out_enable;
        logic        pio_irq;
        logic        ext_irq0;
        logic        ext_irq1;
        logic        ext_fiq;
        logic [31:0] multi_drive_mask;
        logic [31:0] pullup_off_mask;
    } t_result;

endpackage

// ===== sv/gpiosc_regs.sv =====
module gpiosc_regs #(
    parameter int LINES    = 32,
    parameter int IRQ0_PIN = 20,
    parameter int IRQ1_PIN = 30,
    parameter int FIQ_PIN  = 19
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  gpiosc_pkg::t_req    i_req,
    output gpiosc_pkg::t_result o_res
);

    localparam logic [31:0] LineMask = 32'((64'd1 << LINES) - 64'd1);

    logic [31:0] r_pio_en, r_out_en, r_flt_en, r_out_data, r_pins, r_irq_mask;
    logic [31:0] r_irq_stat, r_md, r_pu_dis, r_sel_b, r_wr_en, r_per_a, r_per_b;
    logic [31:0] n_pio_en, n_out_en, n_flt_en, n_out_data, n_pins, n_irq_mask;
    logic [31:0] n_irq_stat, n_md, n_pu_dis, n_sel_b, n_wr_en, n_per_a, n_per_b;
    logic [31:0] w_data, w_rd, w_per_ab, w_level;
    logic        w_err;

    assign w_data = i_req.data_in & LineMask;

    // Register file decode and next state
    always_comb begin
        n_pio_en   = r_pio_en;
        n_out_en   = r_out_en;
        n_flt_en   = r_flt_en;
        n_out_data = r_out_data;
        n_pins     = r_pins;
        n_irq_mask = r_irq_mask;
        n_irq_stat = r_irq_stat;
        n_md       = r_md;
        n_pu_dis   = r_pu_dis;
        n_sel_b    = r_sel_b;
        n_wr_en    = r_wr_en;
        n_per_a    = r_per_a;
        n_per_b    = r_per_b;
        w_rd       = '0;
        w_err      = 1'b0;
        unique case (i_req.func)
            gpiosc_pkg::FUNC_WRITE: begin
                if (!i_req.word_access) begin
                    w_err = 1'b1;
                end else begin
                    unique case (i_req.reg_offset)
                        gpiosc_pkg::OFF_PIO_EN:   n_pio_en   = r_pio_en | w_data;
                        gpiosc_pkg::OFF_PIO_DIS:  n_pio_en   = r_pio_en & ~w_data;
                        gpiosc_pkg::OFF_OUT_EN:   n_out_en   = r_out_en | w_data;
                        gpiosc_pkg::OFF_OUT_DIS:  n_out_en   = r_out_en & ~w_data;
                        gpiosc_pkg::OFF_FLT_EN:   n_flt_en   = r_flt_en | w_data;
                        gpiosc_pkg::OFF_FLT_DIS:  n_flt_en   = r_flt_en & ~w_data;
                        gpiosc_pkg::OFF_SET_DATA: n_out_data = r_out_data | (w_data & ~r_wr_en);
                        gpiosc_pkg::OFF_CLR_DATA: n_out_data = r_out_data & ~(w_data & ~r_wr_en);
                        gpiosc_pkg::OFF_DATA:
                            n_out_data = (r_out_data & ~r_wr_en) | (w_data & r_wr_en);
                        gpiosc_pkg::OFF_IRQ_EN:   n_irq_mask = r_irq_mask | w_data;
                        gpiosc_pkg::OFF_IRQ_DIS:  n_irq_mask = r_irq_mask & ~w_data;
                        gpiosc_pkg::OFF_MD_EN:    n_md       = r_md | w_data;
                        gpiosc_pkg::OFF_MD_DIS:   n_md       = r_md & ~w_data;
                        gpiosc_pkg::OFF_PU_DIS:   n_pu_dis   = r_pu_dis | w_data;
                        gpiosc_pkg::OFF_PU_EN:    n_pu_dis   = r_pu_dis & ~w_data;
                        gpiosc_pkg::OFF_SEL_A:    n_sel_b    = r_sel_b & ~w_data;
                        gpiosc_pkg::OFF_SEL_B:    n_sel_b    = r_sel_b | w_data;
                        gpiosc_pkg::OFF_WR_EN:    n_wr_en    = r_wr_en | w_data;
                        gpiosc_pkg::OFF_WR_DIS:   n_wr_en    = r_wr_en & ~w_data;
                        default:                  w_err      = 1'b1;
                    endcase
                end
            end
            gpiosc_pkg::FUNC_READ: begin
                if (!i_req.word_access) begin
                    w_err = 1'b1;
                end else begin
                    unique case (i_req.reg_offset)
                        gpiosc_pkg::OFF_PIO_STAT: w_rd = r_pio_en;
                        gpiosc_pkg::OFF_OUT_STAT: w_rd = r_out_en;
                        gpiosc_pkg::OFF_FLT_STAT: w_rd = r_flt_en;
                        gpiosc_pkg::OFF_DATA:     w_rd = r_out_data;
                        gpiosc_pkg::OFF_PIN_STAT: w_rd = r_pins;
                        gpiosc_pkg::OFF_IRQ_MASK: w_rd = r_irq_mask;
                        gpiosc_pkg::OFF_IRQ_STAT: begin
                            w_rd = r_irq_stat;
                            // debugger reads leave the status intact
                            if (!i_req.debugger_access) begin
                                n_irq_stat = '0;
                            end
                        end
                        gpiosc_pkg::OFF_MD_STAT:  w_rd = r_md;
                        gpiosc_pkg::OFF_PU_STAT:  w_rd = r_pu_dis;
                        gpiosc_pkg::OFF_SEL_STAT: w_rd = r_sel_b;
                        gpiosc_pkg::OFF_WR_STAT:  w_rd = r_wr_en;
                        default:                  w_err = 1'b1;
                    endcase
                end
            end
            gpiosc_pkg::FUNC_PIN: begin
                // any change on a line latches into the status
                n_irq_stat = r_irq_stat | (w_data ^ r_pins);
                n_pins     = w_data;
            end
            gpiosc_pkg::FUNC_PERA: n_per_a = w_data;
            gpiosc_pkg::FUNC_PERB: n_per_b = w_data;
            default: ;
        endcase
    end

    // Output muxing on the post-transfer state
    assign w_per_ab = (n_per_a & ~n_sel_b) | (n_per_b & n_sel_b);
    assign w_level  = (w_per_ab & ~n_pio_en) | (n_out_data & n_pio_en);

    always_comb begin
        o_res.read_data        = w_rd;
        o_res.access_error     = w_err;
        o_res.pin_out          = w_level & LineMask;
        o_res.pin_out_enable   = n_out_en & LineMask;
        o_res.pio_irq          = |(n_irq_stat & n_irq_mask);
        o_res.ext_irq0         = n_pins[IRQ0_PIN];
        o_res.ext_irq1         = n_pins[IRQ1_PIN];
        o_res.ext_fiq          = n_pins[FIQ_PIN];
        o_res.multi_drive_mask = n_md & LineMask;
        o_res.pullup_off_mask  = n_pu_dis & LineMask;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pio_en   <= '0;
            r_out_en   <= '0;
            r_flt_en   <= '0;
            r_out_data <= '0;
            r_pins     <= LineMask;
            r_irq_mask <= '0;
            r_irq_stat <= '0;
            r_md       <= '0;
            r_pu_dis   <= '0;
            r_sel_b    <= '0;
            r_wr_en    <= '0;
            r_per_a    <= '0;
            r_per_b    <= '0;
        end else if (i_step) begin
            r_pio_en   <= n_pio_en;
            r_out_en   <= n_out_en;
            r_flt_en   <= n_flt_en;
            r_out_data <= n_out_data;
            r_pins     <= n_pins;
            r_irq_mask <= n_irq_mask;
            r_irq_stat <= n_irq_stat;
            r_md       <= n_md;
            r_pu_dis   <= n_pu_dis;
            r_sel_b    <= n_sel_b;
            r_wr_en    <= n_wr_en;
            r_per_a    <= n_per_a;
            r_per_b    <= n_per_b;
        end
    end

endmodule

// ===== sv/gpio_controller_set_clear_regs.sv =====
// 32-line parallel I/O controller with set/clear register pairs.
// Input channel (i_in_valid / o_in_ready): one item per transfer, either a
// bus write, a bus read, a new set of pin levels, or new output levels from
// peripheral A or B, selected by i_func.
// Output channel (o_out_valid / i_out_ready): exactly one result per item,
// in order: read data and error flag for bus accesses, plus the muxed pin
// levels, output enables, interrupt line and pass-through pins as they stand
// after the item.
// Path: an item, once transferred, sits in the input register and is
// applied to the register file as it moves into the result register,
// from which its result is valid.
// Throughput: one item per cycle unless the output stalls; the register
// file update is a single level of masking logic between the input and result registers.
// Stalls: while the result register is held, the input register keeps one
// more item; o_in_ready drops only when both are full and the receiver
// does not take the result.
// Reset (i_rst_n low, synchronous): both channels empty, all masks and
// data cleared, pin levels all ones on the implemented lines.
`include "gpio_controller_set_clear_regs_defines.svh"

module gpio_controller_set_clear_regs #(
    parameter int LINES    = 32,
    parameter int IRQ0_PIN = 20,
    parameter int IRQ1_PIN = 30,
    parameter int FIQ_PIN  = 19
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_reg_offset,
    input  logic        i_word_access,
    input  logic [31:0] i_data_in,
    input  logic        i_debugger_access,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic        o_access_error,
    output logic [31:0] o_pin_out,
    output logic [31:0] o_pin_out_enable,
    output logic        o_pio_irq,
    output logic        o_ext_irq0,
    output logic        o_ext_irq1,
    output logic        o_ext_fiq,
    output logic [31:0] o_multi_drive_mask,
    output logic [31:0] o_pullup_off_mask
);

    localparam logic [31:0] LineMask = 32'((64'd1 << LINES) - 64'd1);

    logic                r_in_valid, r_out_valid;
    gpiosc_pkg::t_req    r_req;
    gpiosc_pkg::t_result r_res, w_res;
    logic                w_advance;

    // Move the held item into the result register when that is free
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    gpiosc_regs #(
        .LINES    (LINES),
        .IRQ0_PIN (IRQ0_PIN),
        .IRQ1_PIN (IRQ1_PIN),
        .FIQ_PIN  (FIQ_PIN)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_req   (r_req),
        .o_res   (w_res)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req.func            <= gpiosc_pkg::t_func'(i_func);
            r_req.reg_offset      <= i_reg_offset;
            r_req.word_access     <= i_word_access;
            r_req.data_in         <= i_data_in;
            r_req.debugger_access <= i_debugger_access;
        end
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_read_data        = r_res.read_data;
    assign o_access_error     = r_res.access_error;
    assign o_pin_out          = r_res.pin_out;
    assign o_pin_out_enable   = r_res.pin_out_enable;
    assign o_pio_irq          = r_res.pio_irq;
    assign o_ext_irq0         = r_res.ext_irq0;
    assign o_ext_irq1         = r_res.ext_irq1;
    assign o_ext_fiq          = r_res.ext_fiq;
    assign o_multi_drive_mask = r_res.multi_drive_mask;
    assign o_pullup_off_mask  = r_res.pullup_off_mask;

    // Checks
    `GCSR_ASSERT_NEXT(a_held_item_moves, i_clk, i_rst_n,
        r_in_valid && !r_out_valid, r_out_valid, "held item did not reach result register")
    `GCSR_ASSERT_NOW(a_err_reads_zero, i_clk, i_rst_n,
        o_out_valid && o_access_error, o_read_data == 32'd0, "failed access returned data")
    `GCSR_ASSERT_NOW(a_unused_lines_low, i_clk, i_rst_n,
        o_out_valid, ((o_pin_out | o_pin_out_enable) & ~LineMask) == 32'd0,
        "unimplemented line active")

endmodule
